### rtl/pkar_pkg.sv
`timescale 1ns / 1ps

package pkar_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] FUNC_KEY        = 2'd0;
    localparam logic [1:0] FUNC_GRAVE      = 2'd1;
    localparam logic [1:0] FUNC_CFG_TOGGLE = 2'd2;
    localparam logic [1:0] FUNC_TICK       = 2'd3;

    localparam logic [1:0] ACT_PASS     = 2'd0;
    localparam logic [1:0] ACT_CONSUMED = 2'd1;
    localparam logic [1:0] ACT_PRESS    = 2'd2;
    localparam logic [1:0] ACT_RELEASE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_KEY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 3'd5;

    localparam logic [15:0] INIT_MIN_RST   = 16'd120;
    localparam logic [15:0] INIT_MAX_RST   = 16'd350;
    localparam logic [15:0] REPEAT_MIN_RST = 16'd110;
    localparam logic [15:0] REPEAT_MAX_RST = 16'd250;
    localparam logic [5:0]  ESCAPE_RST     = 6'd37;
    localparam logic [15:0] SEED_RST       = 16'd1;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [4:0]  MOD_STEPS = 5'd16;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  key_index;
        logic        pressed;
        logic [31:0] time_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] key_out;
        logic       settings_changed;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_t;

    typedef struct packed {
        logic        enabled;
        logic        held;
        logic        released;
        logic        auto_pressed;
        logic [31:0] due_ms;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVENT,
        S_SCAN,
        S_DRAW,
        S_WRITE,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic cap_in;
        logic rd_key;
        logic rd_first;
        logic rd_next;
        logic eval;
        logic draw;
        logic write;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic fire;
        logic need_draw;
        logic draw_done;
        logic out_free;
        logic pend_valid;
        logic scan_last;
    } stat_t;

endpackage

### rtl/pkar_chan_if.sv
`timescale 1ns / 1ps

interface pkar_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/per_key_jittered_auto_repeat_core.sv
`timescale 1ns / 1ps
// A key event passes through the read, event and write states, and a draw state when a
// random delay is drawn, to its result beat; the shared remainder unit resolves one bit per
// cycle. A scan tick reads key entries one per cycle unless a firing key waits on a busy
// result output, and draws a delay for each firing key; one item is processed at a time.
// Reset clears the key valid bits, configuration mode and the result valid flags at once,
// loads the default delays and reseeds the jitter LFSR; no clearing pass is needed.

module per_key_jittered_auto_repeat_core #(
    parameter int NUM_KEYS = 64
) (
    input logic         clk,
    input logic         rst_n,
    pkar_chan_if.sink   item,
    pkar_chan_if.source result,
    pkar_chan_if.sink   cfg
);
    import pkar_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg.ready = 1'b1;

    pkar_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    pkar_datapath #(.NUM_KEYS(NUM_KEYS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .item_data (item.data),
        .res_ready (result.ready),
        .res_valid (result.valid),
        .res_data  (result.data),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data)
    );
endmodule

### rtl/pkar_ram.sv
`timescale 1ns / 1ps

module pkar_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### rtl/pkar_mod_unit.sv
`timescale 1ns / 1ps

module pkar_mod_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [15:0] rem
);
    import pkar_pkg::*;

    logic        busy_reg;
    logic [4:0]  step_reg;
    logic [15:0] num_reg;
    logic [16:0] rem_reg;
    logic [16:0] div_reg;
    logic [17:0] trial;
    logic [17:0] diff;

    assign trial = {rem_reg, num_reg[15]};
    assign diff  = trial - {1'b0, div_reg};
    assign done  = busy_reg && (step_reg == 5'd0);
    assign rem   = rem_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= MOD_STEPS;
        end
        else if (busy_reg)
        begin
            if (step_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= 17'd0;
            div_reg <= divisor;
        end
        else if (busy_reg && (step_reg != 5'd0))
        begin
            num_reg <= {num_reg[14:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= diff[16:0];
            end
            else
            begin
                rem_reg <= trial[16:0];
            end
        end
    end
endmodule

### rtl/pkar_datapath.sv
`timescale 1ns / 1ps

module pkar_datapath #(
    parameter int NUM_KEYS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pkar_pkg::cmd_t    cmd,
    output pkar_pkg::stat_t   stat,
    input  pkar_pkg::item_t   item_data,
    input  logic              res_ready,
    output logic              res_valid,
    output pkar_pkg::result_t res_data,
    input  logic              cfg_valid,
    input  pkar_pkg::cfg_t    cfg_data
);
    import pkar_pkg::*;

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int EW = $bits(entry_t);

    logic [15:0] init_min_reg;
    logic [15:0] init_max_reg;
    logic [15:0] rep_min_reg;
    logic [15:0] rep_max_reg;
    logic [5:0]  esc_reg;
    logic [15:0] lfsr_reg;
    logic        cm_reg;

    item_t       in_reg;
    logic [KW-1:0] cnt_reg;
    logic [NUM_KEYS-1:0] valid_reg;
    entry_t      entry_reg;
    logic        wr_flag_reg;
    logic        draw_flag_reg;
    logic [15:0] lo_reg;

    logic        pend_valid_reg;
    logic [1:0]  pend_act_reg;
    logic [5:0]  pend_key_reg;
    logic        pend_chg_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic          is_tick;
    logic [8:0]    key_w;
    logic [8:0]    cnt_w;
    logic          in_range;
    logic [KW-1:0] key_addr;
    logic [KW-1:0] cur_addr;
    logic          rd_en;
    logic [KW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          wr_en;
    entry_t        wr_entry;
    entry_t        ent;
    entry_t        ent_new;
    logic [1:0]    ev_act;
    logic [5:0]    ev_key;
    logic          ev_chg;
    logic          ev_wr;
    logic          ev_draw;
    logic          fire;
    logic          cm_next;
    logic [15:0]   lo;
    logic [15:0]   hi;
    logic [16:0]   span;
    logic [15:0]   lfsr_step;
    logic          mod_done;
    logic [15:0]   mod_rem;
    logic          out_free;
    logic          out_load;

    assign is_tick  = (in_reg.func == FUNC_TICK);
    assign key_w    = {3'b000, in_reg.key_index};
    assign cnt_w    = 9'(cnt_reg);
    assign in_range = key_w < 9'(NUM_KEYS);
    assign key_addr = KW'(key_w);
    assign cur_addr = is_tick ? cnt_reg : key_addr;

    always_comb
    begin
        rd_addr = key_addr;
        if (cmd.rd_first)
        begin
            rd_addr = '0;
        end
        else if (cmd.rd_next)
        begin
            rd_addr = cnt_reg + KW'(1);
        end
    end
    assign rd_en = cmd.rd_key || cmd.rd_first || cmd.rd_next;

    assign wr_en = cmd.write && wr_flag_reg;
    always_comb
    begin
        wr_entry = entry_reg;
        if (draw_flag_reg)
        begin
            wr_entry.due_ms = in_reg.time_ms + 32'(lo_reg) + 32'(mod_rem);
        end
    end

    pkar_ram #(.WIDTH(EW), .DEPTH(NUM_KEYS), .AW(KW)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_addr),
        .wr_data (EW'(wr_entry)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ent = valid_reg[cur_addr] ? entry_t'(rd_data) : entry_t'('0);

    always_comb
    begin
        ent_new = ent;
        ev_act  = ACT_CONSUMED;
        ev_key  = in_reg.key_index;
        ev_chg  = 1'b0;
        ev_wr   = 1'b0;
        ev_draw = 1'b0;
        fire    = 1'b0;
        cm_next = cm_reg;
        case (in_reg.func)
            FUNC_TICK:
            begin
                ev_key = cnt_w[5:0];
                fire   = ent.enabled && ent.held && (ent.due_ms <= in_reg.time_ms);
                if (!ent.released)
                begin
                    ev_act = ACT_RELEASE;
                    ent_new.released = 1'b1;
                    ent_new.auto_pressed = 1'b0;
                end
                else if (!ent.auto_pressed)
                begin
                    ev_act = ACT_PRESS;
                    ent_new.auto_pressed = 1'b1;
                end
                else
                begin
                    ev_act = ACT_RELEASE;
                    ent_new.auto_pressed = 1'b0;
                end
                ev_wr   = fire;
                ev_draw = fire;
            end
            FUNC_GRAVE:
            begin
                ev_key = 6'd0;
                if (cm_reg)
                begin
                    cm_next = 1'b0;
                end
                else
                begin
                    ev_act = ACT_PASS;
                end
            end
            FUNC_CFG_TOGGLE:
            begin
                ev_key = 6'd0;
                if (!in_reg.pressed)
                begin
                    cm_next = !cm_reg;
                end
            end
            FUNC_KEY:
            begin
                if (!in_range)
                begin
                    ev_act = ACT_PASS;
                end
                else if (cm_reg && (in_reg.key_index == esc_reg))
                begin
                    cm_next = 1'b0;
                end
                else if (cm_reg)
                begin
                    ev_wr = 1'b1;
                    if (!in_reg.pressed)
                    begin
                        ent_new.enabled = !ent.enabled;
                        ev_chg = 1'b1;
                    end
                end
                else
                begin
                    ev_wr = 1'b1;
                    ent_new.held = in_reg.pressed;
                    if (!ent.enabled)
                    begin
                        ev_act = ACT_PASS;
                    end
                    else if (in_reg.pressed)
                    begin
                        ent_new.released = 1'b0;
                        ev_draw = 1'b1;
                        ev_act = ACT_PRESS;
                    end
                    else if (((in_reg.time_ms < ent.due_ms) && !ent.released)
                             || ent.auto_pressed)
                    begin
                        ent_new.auto_pressed = 1'b0;
                        ev_act = ACT_RELEASE;
                    end
                end
            end
            default:
            begin
                ev_act = ACT_PASS;
            end
        endcase
    end

    assign lo   = is_tick ? rep_min_reg : init_min_reg;
    assign hi   = is_tick ? rep_max_reg : init_max_reg;
    assign span = (hi < lo) ? 17'd1 : ({1'b0, hi} - {1'b0, lo} + 17'd1);
    assign lfsr_step = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 16'd0);

    pkar_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.draw),
        .dividend (lfsr_step),
        .divisor  (span),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_min_reg <= INIT_MIN_RST;
            init_max_reg <= INIT_MAX_RST;
            rep_min_reg  <= REPEAT_MIN_RST;
            rep_max_reg  <= REPEAT_MAX_RST;
            esc_reg      <= ESCAPE_RST;
            lfsr_reg     <= SEED_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_data.index)
                REG_INIT_MIN:   init_min_reg <= cfg_data.data;
                REG_INIT_MAX:   init_max_reg <= cfg_data.data;
                REG_REPEAT_MIN: rep_min_reg  <= cfg_data.data;
                REG_REPEAT_MAX: rep_max_reg  <= cfg_data.data;
                REG_ESCAPE_KEY: esc_reg      <= cfg_data.data[5:0];
                REG_SEED:       lfsr_reg     <= (cfg_data.data == 16'd0) ? 16'd1 : cfg_data.data;
                default:        ;
            endcase
        end
        else if (cmd.draw)
        begin
            lfsr_reg <= lfsr_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cm_reg         <= 1'b0;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                cm_reg <= cm_next;
            end
            if (wr_en)
            begin
                valid_reg[cur_addr] <= 1'b1;
            end
            if (cmd.rd_first)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.rd_next)
            begin
                cnt_reg <= cnt_reg + KW'(1);
            end
            if (cmd.eval)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_load || (out_valid_reg && !res_ready);
        end
    end

    assign out_free = !out_valid_reg || res_ready;
    assign out_load = (cmd.eval && pend_valid_reg) || cmd.flush;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            in_reg <= item_data;
        end
        if (cmd.eval)
        begin
            entry_reg     <= ent_new;
            wr_flag_reg   <= ev_wr;
            draw_flag_reg <= cmd.draw;
            pend_act_reg  <= ev_act;
            pend_key_reg  <= ev_key;
            pend_chg_reg  <= ev_chg;
        end
        if (cmd.draw)
        begin
            lo_reg <= lo;
        end
        if (out_load)
        begin
            out_reg.action           <= pend_act_reg;
            out_reg.key_out          <= pend_key_reg;
            out_reg.settings_changed <= pend_chg_reg;
            out_reg.last             <= cmd.flush;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    assign stat.is_tick    = is_tick;
    assign stat.fire       = fire;
    assign stat.need_draw  = ev_draw;
    assign stat.draw_done  = mod_done;
    assign stat.out_free   = out_free;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.scan_last  = (cnt_reg == KW'(NUM_KEYS - 1));
endmodule

### rtl/pkar_ctrl.sv
`timescale 1ns / 1ps

module pkar_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  pkar_pkg::stat_t stat,
    output pkar_pkg::cmd_t  cmd
);
    import pkar_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = stat.is_tick ? S_SCAN : S_EVENT;
            end
            S_EVENT:
            begin
                state_next = stat.need_draw ? S_DRAW : S_WRITE;
            end
            S_SCAN:
            begin
                if (stat.fire)
                begin
                    if (!stat.pend_valid || stat.out_free)
                    begin
                        state_next = S_DRAW;
                    end
                end
                else if (stat.scan_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_DRAW:
            begin
                if (stat.draw_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = (stat.is_tick && !stat.scan_last) ? S_SCAN : S_FLUSH;
            end
            S_FLUSH:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                cmd.cap_in = item_valid;
            end
            S_READ:
            begin
                cmd.rd_first = stat.is_tick;
                cmd.rd_key   = !stat.is_tick;
            end
            S_EVENT:
            begin
                cmd.eval = 1'b1;
                cmd.draw = stat.need_draw;
            end
            S_SCAN:
            begin
                if (stat.fire)
                begin
                    if (!stat.pend_valid || stat.out_free)
                    begin
                        cmd.eval = 1'b1;
                        cmd.draw = 1'b1;
                    end
                end
                else if (!stat.scan_last)
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_WRITE:
            begin
                cmd.write   = 1'b1;
                cmd.rd_next = stat.is_tick && !stat.scan_last;
            end
            S_FLUSH:
            begin
                cmd.flush = stat.pend_valid && stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pkar_pkg::*;

    localparam int NUM_KEYS = 64;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        item_t   stim;
        logic    typed;
        result_t want;
    } row_t;

    logic clk;
    logic rst_n;

    pkar_chan_if #(.T(item_t))   item_if ();
    pkar_chan_if #(.T(result_t)) res_if ();
    pkar_chan_if #(.T(cfg_t))    cfg_if ();

    per_key_jittered_auto_repeat_core #(
        .NUM_KEYS(NUM_KEYS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_if),
        .result(res_if),
        .cfg(cfg_if)
    );

    logic [15:0] init_min;
    logic [15:0] init_max;
    logic [15:0] rep_min;
    logic [15:0] rep_max;
    logic [5:0]  esc_key;
    logic [15:0] jitter;
    logic        cfg_mode;
    logic        key_on [NUM_KEYS];
    logic        key_down [NUM_KEYS];
    logic        key_rel [NUM_KEYS];
    logic        key_rpt [NUM_KEYS];
    logic [31:0] key_due [NUM_KEYS];

    result_t     due_actions[$];
    row_t        script[$];
    logic [5:0]  key_pool [8];
    logic [31:0] clock_ms;
    int          mismatches;
    int          events_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_req;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("per_key_jittered_auto_repeat_core test failed");
        $finish;
    end

    function automatic logic [31:0] draw_jitter(input logic [15:0] lo, input logic [15:0] hi);
        logic [15:0] s;
        logic [31:0] span;
        s = jitter >> 1;
        if (jitter[0])
            s = s ^ LFSR_TAPS;
        jitter = s;
        span = (hi < lo) ? 32'd1 : 32'(hi) - 32'(lo) + 32'd1;
        return 32'(lo) + 32'(s) % span;
    endfunction

    function automatic item_t mk(input logic [1:0] f, input logic [5:0] k, input logic p,
                                 input logic [31:0] t);
        item_t it;
        it.func = f;
        it.key_index = k;
        it.pressed = p;
        it.time_ms = t;
        return it;
    endfunction

    task automatic typematic_step(input item_t it);
        result_t r;
        result_t prev;
        logic    have_prev;
        logic [5:0] k;
        r = '0;
        r.last = 1'b1;
        prev = '0;
        have_prev = 1'b0;
        k = it.key_index;
        case (it.func)
            FUNC_TICK:
            begin
                for (int i = 0; i < NUM_KEYS; i++)
                begin
                    if (key_on[i] && key_down[i] && key_due[i] <= it.time_ms)
                    begin
                        if (have_prev)
                            due_actions.push_back(prev);
                        prev = '0;
                        prev.key_out = 6'(i);
                        if (!key_rel[i])
                        begin
                            prev.action = ACT_RELEASE;
                            key_rel[i] = 1'b1;
                            key_rpt[i] = 1'b0;
                        end
                        else if (!key_rpt[i])
                        begin
                            prev.action = ACT_PRESS;
                            key_rpt[i] = 1'b1;
                        end
                        else
                        begin
                            prev.action = ACT_RELEASE;
                            key_rpt[i] = 1'b0;
                        end
                        key_due[i] = it.time_ms + draw_jitter(rep_min, rep_max);
                        have_prev = 1'b1;
                    end
                end
                if (have_prev)
                begin
                    prev.last = 1'b1;
                    due_actions.push_back(prev);
                end
            end
            FUNC_GRAVE:
            begin
                r.action = cfg_mode ? ACT_CONSUMED : ACT_PASS;
                cfg_mode = 1'b0;
                due_actions.push_back(r);
            end
            FUNC_CFG_TOGGLE:
            begin
                if (!it.pressed)
                    cfg_mode = !cfg_mode;
                r.action = ACT_CONSUMED;
                due_actions.push_back(r);
            end
            default:
            begin
                r.key_out = k;
                if (cfg_mode && k == esc_key)
                begin
                    cfg_mode = 1'b0;
                    r.action = ACT_CONSUMED;
                end
                else if (cfg_mode)
                begin
                    if (!it.pressed)
                    begin
                        key_on[k] = !key_on[k];
                        r.settings_changed = 1'b1;
                    end
                    r.action = ACT_CONSUMED;
                end
                else
                begin
                    key_down[k] = it.pressed;
                    if (!key_on[k])
                        r.action = ACT_PASS;
                    else if (it.pressed)
                    begin
                        key_rel[k] = 1'b0;
                        key_due[k] = it.time_ms + draw_jitter(init_min, init_max);
                        r.action = ACT_PRESS;
                    end
                    else if ((it.time_ms < key_due[k] && !key_rel[k]) || key_rpt[k])
                    begin
                        key_rpt[k] = 1'b0;
                        r.action = ACT_RELEASE;
                    end
                    else
                        r.action = ACT_CONSUMED;
                end
                due_actions.push_back(r);
            end
        endcase
    endtask

    task automatic offer_item(input item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        item_if.valid <= 1'b1;
        item_if.data <= it;
        do @(posedge clk); while (!item_if.ready);
        typematic_step(it);
        events_sent++;
    endtask

    task automatic settle_block();
        item_if.valid <= 1'b0;
        while (due_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= {idx, val};
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_INIT_MIN:   init_min = val;
            REG_INIT_MAX:   init_max = val;
            REG_REPEAT_MIN: rep_min = val;
            REG_REPEAT_MAX: rep_max = val;
            REG_ESCAPE_KEY: esc_key = val[5:0];
            REG_SEED:       jitter = (val == 16'd0) ? 16'd1 : val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_setting(input logic [15:0] i0, input logic [15:0] i1,
                                input logic [15:0] r0, input logic [15:0] r1,
                                input logic [5:0] esc, input logic [15:0] seed);
        settle_block();
        write_reg(REG_INIT_MIN, i0);
        write_reg(REG_INIT_MAX, i1);
        write_reg(REG_REPEAT_MIN, r0);
        write_reg(REG_REPEAT_MAX, r1);
        write_reg(REG_ESCAPE_KEY, {10'd0, esc});
        write_reg(REG_SEED, seed);
        foreach (key_pool[i])
            key_pool[i] = 6'($urandom);
    endtask

    task automatic add_row(input logic [1:0] f, input logic [5:0] k, input logic p,
                           input logic [31:0] t, input logic typed,
                           input logic [1:0] act, input logic [5:0] ko, input logic chg);
        row_t row;
        row.stim = mk(f, k, p, t);
        row.typed = typed;
        row.want.action = act;
        row.want.key_out = ko;
        row.want.settings_changed = chg;
        row.want.last = 1'b1;
        script.push_back(row);
    endtask

    task automatic random_phase(input int target);
        int first;
        int n;
        logic [5:0] k;
        logic [5:0] k2;
        int pick;
        first = events_sent;
        while (events_sent - first < target)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                offer_item(mk(FUNC_CFG_TOGGLE, 6'($urandom), 1'b1, clock_ms));
                offer_item(mk(FUNC_CFG_TOGGLE, 6'($urandom), 1'b0, clock_ms));
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    k = key_pool[$urandom_range(7)];
                    offer_item(mk(FUNC_KEY, k, 1'b1, clock_ms));
                    offer_item(mk(FUNC_KEY, k, 1'b0, clock_ms));
                end
                case ($urandom_range(2))
                    0:
                    begin
                        offer_item(mk(FUNC_CFG_TOGGLE, 6'($urandom), 1'b1, clock_ms));
                        offer_item(mk(FUNC_CFG_TOGGLE, 6'($urandom), 1'b0, clock_ms));
                    end
                    1: offer_item(mk(FUNC_GRAVE, 6'($urandom), 1'($urandom), clock_ms));
                    default: offer_item(mk(FUNC_KEY, esc_key, 1'($urandom), clock_ms));
                endcase
            end
            else if (pick < 72)
            begin
                k = key_pool[$urandom_range(7)];
                k2 = key_pool[$urandom_range(7)];
                offer_item(mk(FUNC_KEY, k, 1'b1, clock_ms));
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    clock_ms += $urandom_range(0, 300);
                    if ($urandom_range(3) == 0)
                        offer_item(mk(FUNC_KEY, k2, 1'($urandom), clock_ms));
                    offer_item(mk(FUNC_TICK, 6'($urandom), 1'($urandom), clock_ms));
                end
                clock_ms += $urandom_range(0, 100);
                offer_item(mk(FUNC_KEY, k, 1'b0, clock_ms));
            end
            else if (pick < 92)
                offer_item(mk(2'($urandom), 6'($urandom), 1'($urandom),
                              $urandom_range(1) ? clock_ms : $urandom));
            else
            begin
                if ($urandom_range(1))
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
                else
                    clock_ms += $urandom_range(0, 70000);
                offer_item(mk(FUNC_TICK, 6'($urandom), 1'($urandom), clock_ms));
            end
        end
    endtask

    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_if.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        result_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = res_if.data;
            if (due_actions.size() == 0)
            begin
                $display("%0t: unexpected result beat, ", $time,
                         "got action %0d key %0d changed %0d last %0d",
                         got.action, got.key_out, got.settings_changed, got.last);
                mismatches++;
            end
            else
            begin
                want = due_actions.pop_front();
                if (got.action !== want.action || got.key_out !== want.key_out ||
                    got.settings_changed !== want.settings_changed || got.last !== want.last)
                begin
                    $display("%0t: result mismatch, ", $time,
                             "expected action %0d key %0d changed %0d last %0d, ",
                             want.action, want.key_out, want.settings_changed, want.last,
                             "got action %0d key %0d changed %0d last %0d",
                             got.action, got.key_out, got.settings_changed, got.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        hold_req = 1'b0;
        mismatches = 0;
        events_sent = 0;
        clock_ms = 32'd0;
        send_idle_pct = 36;
        recv_idle_pct = 48;
        init_min = INIT_MIN_RST;
        init_max = INIT_MAX_RST;
        rep_min = REPEAT_MIN_RST;
        rep_max = REPEAT_MAX_RST;
        esc_key = ESCAPE_RST;
        jitter = SEED_RST;
        cfg_mode = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            key_on[i] = 1'b0;
            key_down[i] = 1'b0;
            key_rel[i] = 1'b0;
            key_rpt[i] = 1'b0;
            key_due[i] = 32'd0;
        end

        add_row(FUNC_KEY, 6'd0, 1'b1, 32'd0, 1'b1, ACT_PASS, 6'd0, 1'b0);
        add_row(FUNC_KEY, 6'd63, 1'b0, 32'hFFFF_FFFF, 1'b1, ACT_PASS, 6'd63, 1'b0);
        add_row(FUNC_GRAVE, 6'd0, 1'b1, 32'd0, 1'b1, ACT_PASS, 6'd0, 1'b0);
        add_row(FUNC_TICK, 6'd0, 1'b0, 32'd0, 1'b0, ACT_PASS, 6'd0, 1'b0);
        add_row(FUNC_CFG_TOGGLE, 6'd0, 1'b1, 32'd0, 1'b1, ACT_CONSUMED, 6'd0, 1'b0);
        add_row(FUNC_CFG_TOGGLE, 6'd0, 1'b0, 32'd0, 1'b1, ACT_CONSUMED, 6'd0, 1'b0);
        add_row(FUNC_KEY, 6'd0, 1'b1, 32'd0, 1'b1, ACT_CONSUMED, 6'd0, 1'b0);
        add_row(FUNC_KEY, 6'd0, 1'b0, 32'd0, 1'b1, ACT_CONSUMED, 6'd0, 1'b1);
        add_row(FUNC_KEY, 6'd63, 1'b0, 32'd0, 1'b1, ACT_CONSUMED, 6'd63, 1'b1);
        add_row(FUNC_KEY, 6'd42, 1'b0, 32'd0, 1'b1, ACT_CONSUMED, 6'd42, 1'b1);
        add_row(FUNC_KEY, 6'd21, 1'b0, 32'd0, 1'b1, ACT_CONSUMED, 6'd21, 1'b1);
        add_row(FUNC_KEY, 6'd37, 1'b0, 32'd0, 1'b1, ACT_CONSUMED, 6'd37, 1'b0);
        add_row(FUNC_KEY, 6'd37, 1'b1, 32'd100, 1'b1, ACT_PASS, 6'd37, 1'b0);
        add_row(FUNC_KEY, 6'd0, 1'b1, 32'd1000, 1'b1, ACT_PRESS, 6'd0, 1'b0);
        add_row(FUNC_KEY, 6'd0, 1'b0, 32'd1001, 1'b1, ACT_RELEASE, 6'd0, 1'b0);
        add_row(FUNC_KEY, 6'd63, 1'b1, 32'hFFFF_FF00, 1'b1, ACT_PRESS, 6'd63, 1'b0);
        add_row(FUNC_KEY, 6'd21, 1'b1, 32'd2000, 1'b1, ACT_PRESS, 6'd21, 1'b0);
        add_row(FUNC_TICK, 6'd63, 1'b1, 32'd2500, 1'b0, ACT_PASS, 6'd0, 1'b0);
        add_row(FUNC_TICK, 6'd0, 1'b0, 32'd2800, 1'b0, ACT_PASS, 6'd0, 1'b0);
        add_row(FUNC_TICK, 6'd0, 1'b0, 32'd3100, 1'b0, ACT_PASS, 6'd0, 1'b0);
        add_row(FUNC_KEY, 6'd21, 1'b0, 32'd3200, 1'b0, ACT_PASS, 6'd0, 1'b0);
        add_row(FUNC_CFG_TOGGLE, 6'd63, 1'b0, 32'd3200, 1'b1, ACT_CONSUMED, 6'd0, 1'b0);
        add_row(FUNC_GRAVE, 6'd63, 1'b0, 32'hFFFF_FFFF, 1'b1, ACT_CONSUMED, 6'd0, 1'b0);
        add_row(FUNC_KEY, 6'd42, 1'b1, 32'hFFFF_FFFF, 1'b1, ACT_PRESS, 6'd42, 1'b0);
        add_row(FUNC_TICK, 6'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, ACT_PASS, 6'd0, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            offer_item(script[i].stim);
            if (script[i].typed)
                due_actions[due_actions.size() - 1] = script[i].want;
        end

        load_setting(16'd0, 16'd0, 16'd0, 16'd0, 6'd0, 16'd0);
        clock_ms = 32'd5000;
        random_phase(78);

        send_idle_pct = 48;
        recv_idle_pct = 36;
        load_setting(16'd65535, 16'd65535, 16'd65535, 16'd0, 6'd63, 16'd65535);
        random_phase(78);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_setting(16'd20, 16'd180, 16'd5, 16'd90, 6'($urandom),
                     16'($urandom_range(1, 65535)));
        hold_req = 1'b1;
        random_phase(78);

        settle_block();
        if (mismatches == 0)
            $display("per_key_jittered_auto_repeat_core test passed");
        else
            $display("per_key_jittered_auto_repeat_core test failed");
        $finish;
    end

endmodule

### per_key_jittered_auto_repeat_core.f
rtl/pkar_pkg.sv
rtl/pkar_chan_if.sv
rtl/pkar_ram.sv
rtl/pkar_mod_unit.sv
rtl/pkar_datapath.sv
rtl/pkar_ctrl.sv
rtl/per_key_jittered_auto_repeat_core.sv
tb/sv/tb.sv
